[rtl/core/arq_receive_window_ack_generator_unit_defines.svh]
// ----------------------------------------------------------------------------
// ARQ receive window assertion macros
// Shared wrappers for the concurrent checks in the receive window block.
// ----------------------------------------------------------------------------
`ifndef ARQ_RECEIVE_WINDOW_ACK_GENERATOR_UNIT_DEFINES_SVH
`define ARQ_RECEIVE_WINDOW_ACK_GENERATOR_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ARQ_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ARQ receive window check failed");

// The consequent must hold in the cycle after the antecedent.
`define ARQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ARQ receive window check failed");

`endif

[rtl/core/arq_rx_pkg.sv]
// ----------------------------------------------------------------------------
// ARQ receive window package
// Widths, codes and shared types of the ARQ receive window block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package arq_rx_pkg;

  localparam int SEQ_W      = 11;
  localparam int CONN_W     = 16;
  localparam int FLAG_W     = 2;
  localparam int WIN_W      = 11;
  localparam int PERIOD_W   = 8;
  localparam int CFG_DATA_W = 11;

  localparam logic [WIN_W-1:0]    WINDOW_SIZE_RESET = WIN_W'(1);
  localparam logic [PERIOD_W-1:0] ACK_PERIOD_RESET  = PERIOD_W'(1);

  localparam logic REG_WINDOW_SIZE = 1'b0;
  localparam logic REG_ACK_PERIOD  = 1'b1;

  localparam logic MODE_NORMAL = 1'b0;

  localparam logic [FLAG_W-1:0] ORDER_OUT_OF_ORDER = 2'd0;
  localparam logic [FLAG_W-1:0] ORDER_IN_ORDER     = 2'd1;
  localparam logic [FLAG_W-1:0] ORDER_OUTSIDE      = 2'd2;

  typedef struct packed {
    logic [WIN_W-1:0]    window_size;
    logic [PERIOD_W-1:0] ack_period;
  } cfg_t;

  typedef struct packed {
    logic              mode;
    logic [SEQ_W-1:0]  sequence_number;
    logic [CONN_W-1:0] connection_id;
    logic [FLAG_W-1:0] order_flag_in;
    logic              open_feedback;
  } item_t;

  typedef struct packed {
    logic [FLAG_W-1:0] order_flag_out;
    logic              cumulative_valid;
    logic [SEQ_W-1:0]  cumulative_number;
    logic              selective_valid;
    logic [SEQ_W-1:0]  selective_number;
    logic [CONN_W-1:0] ack_connection;
    logic              new_message;
  } result_t;

  function automatic logic in_window(input logic [SEQ_W-1:0] delta,
                                     input logic [WIN_W-1:0] size);
    return (delta != '0) && (delta <= size);
  endfunction

endpackage

[rtl/core/arq_rx_cfg.sv]
// ----------------------------------------------------------------------------
// ARQ receive window configuration registers
// Holds the window size and acknowledgement period written over the port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module arq_rx_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic                                cfg_index,
  input  logic [arq_rx_pkg::CFG_DATA_W-1:0]   cfg_data,
  output arq_rx_pkg::cfg_t                    cfg
);

  arq_rx_pkg::cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.window_size <= arq_rx_pkg::WINDOW_SIZE_RESET;
      regs.ack_period  <= arq_rx_pkg::ACK_PERIOD_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        arq_rx_pkg::REG_WINDOW_SIZE: begin
          regs.window_size <= cfg_data[arq_rx_pkg::WIN_W-1:0];
        end
        arq_rx_pkg::REG_ACK_PERIOD: begin
          regs.ack_period <= cfg_data[arq_rx_pkg::PERIOD_W-1:0];
        end
      endcase
    end
  end

  assign cfg = regs;

endmodule

[rtl/core/arq_rx_window.sv]
// ----------------------------------------------------------------------------
// ARQ receive window state and acknowledgement decision
// Classifies one item against the expected number, keeps the expected number
// and reception count, and decides the acknowledgement for that item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module arq_rx_window (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  arq_rx_pkg::item_t    item,
  input  arq_rx_pkg::cfg_t     cfg,
  output arq_rx_pkg::result_t  result
);

  logic [arq_rx_pkg::SEQ_W-1:0]    expected_number;
  logic [arq_rx_pkg::SEQ_W-1:0]    expected_number_next;
  logic [arq_rx_pkg::PERIOD_W-1:0] reception_count;
  logic [arq_rx_pkg::PERIOD_W-1:0] reception_count_next;

  logic                            in_order;
  logic [arq_rx_pkg::SEQ_W-1:0]    ahead_dist;
  logic [arq_rx_pkg::SEQ_W-1:0]    behind_dist;
  logic [arq_rx_pkg::SEQ_W-1:0]    cum_num;
  logic [arq_rx_pkg::PERIOD_W-1:0] count_inc;
  logic                            decide;
  logic [arq_rx_pkg::FLAG_W-1:0]   order;

  always_comb begin
    in_order   = (item.sequence_number == expected_number);
    ahead_dist = item.sequence_number - expected_number;

    if (in_order) begin
      order                = item.order_flag_in;
      expected_number_next = expected_number + arq_rx_pkg::SEQ_W'(1);
    end else begin
      order = arq_rx_pkg::in_window(ahead_dist, cfg.window_size) ?
              arq_rx_pkg::ORDER_OUT_OF_ORDER : arq_rx_pkg::ORDER_OUTSIDE;
      expected_number_next = expected_number;
    end

    count_inc            = reception_count + arq_rx_pkg::PERIOD_W'(1);
    decide               = (count_inc == cfg.ack_period);
    reception_count_next = decide ? '0 : count_inc;

    cum_num     = expected_number_next - arq_rx_pkg::SEQ_W'(1);
    behind_dist = expected_number_next - item.sequence_number;

    result                = '0;
    result.order_flag_out = order;
    if (decide) begin
      if (order == arq_rx_pkg::ORDER_IN_ORDER) begin
        if (arq_rx_pkg::in_window(behind_dist, cfg.window_size)) begin
          result.cumulative_valid  = 1'b1;
          result.cumulative_number = cum_num;
          result.ack_connection    = item.connection_id;
          result.new_message       = !item.open_feedback;
        end
      end else if (order == arq_rx_pkg::ORDER_OUT_OF_ORDER &&
                   item.mode == arq_rx_pkg::MODE_NORMAL) begin
        result.selective_valid  = 1'b1;
        result.selective_number = item.sequence_number;
        result.ack_connection   = item.connection_id;
        if (!item.open_feedback) begin
          result.cumulative_valid  = 1'b1;
          result.cumulative_number = cum_num;
          result.new_message       = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_number <= '0;
      reception_count <= '0;
    end else if (advance) begin
      expected_number <= expected_number_next;
      reception_count <= reception_count_next;
    end
  end

endmodule

[rtl/core/arq_receive_window_ack_generator_unit.sv]
// ----------------------------------------------------------------------------
// ARQ receive window acknowledgement generator
// Selective-repeat receiver window with cumulative and selective ack decision.
// ----------------------------------------------------------------------------
// The block takes one received block as an item in every cycle in which
// in_stall is low and returns exactly one result item for it, through an
// input register and a result register. The rate is one item per clock while
// out_stall is low, set by the update of the expected sequence number and the
// reception counter as an item moves from the input register to the result
// register. Sequence space is 2048; all window distances are modulo it.
`timescale 1ns / 1ps

module arq_receive_window_ack_generator_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic                                  cfg_index,
  input  logic [arq_rx_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  mode,
  input  logic [arq_rx_pkg::SEQ_W-1:0]          sequence_number,
  input  logic [arq_rx_pkg::CONN_W-1:0]         connection_id,
  input  logic [arq_rx_pkg::FLAG_W-1:0]         order_flag_in,
  input  logic                                  open_feedback,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [arq_rx_pkg::FLAG_W-1:0]         order_flag_out,
  output logic                                  cumulative_valid,
  output logic [arq_rx_pkg::SEQ_W-1:0]          cumulative_number,
  output logic                                  selective_valid,
  output logic [arq_rx_pkg::SEQ_W-1:0]          selective_number,
  output logic [arq_rx_pkg::CONN_W-1:0]         ack_connection,
  output logic                                  new_message
);

  `include "arq_receive_window_ack_generator_unit_defines.svh"

  arq_rx_pkg::cfg_t    cfg;
  arq_rx_pkg::item_t   item_q;
  logic                item_valid;
  arq_rx_pkg::result_t result_comb;
  arq_rx_pkg::result_t result_q;
  logic                advance;
  logic                in_accept;

  assign advance   = item_valid && (!out_valid || !out_stall);
  assign in_stall  = item_valid && !advance;
  assign in_accept = in_valid && !in_stall;

  arq_rx_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  arq_rx_window u_window (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (item_q),
    .cfg     (cfg),
    .result  (result_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_accept) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_q.mode            <= mode;
      item_q.sequence_number <= sequence_number;
      item_q.connection_id   <= connection_id;
      item_q.order_flag_in   <= order_flag_in;
      item_q.open_feedback   <= open_feedback;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_q <= result_comb;
    end
  end

  assign order_flag_out    = result_q.order_flag_out;
  assign cumulative_valid  = result_q.cumulative_valid;
  assign cumulative_number = result_q.cumulative_number;
  assign selective_valid   = result_q.selective_valid;
  assign selective_number  = result_q.selective_number;
  assign ack_connection    = result_q.ack_connection;
  assign new_message       = result_q.new_message;

  `ARQ_ASSERT_SAME(a_sel_only_out_of_order, clk, rst,
    out_valid && selective_valid, order_flag_out == arq_rx_pkg::ORDER_OUT_OF_ORDER)
  `ARQ_ASSERT_SAME(a_outside_no_ack, clk, rst,
    out_valid && order_flag_out == arq_rx_pkg::ORDER_OUTSIDE,
    !cumulative_valid && !selective_valid)
  `ARQ_ASSERT_SAME(a_new_msg_has_cum, clk, rst,
    out_valid && new_message, cumulative_valid)
  `ARQ_ASSERT_SAME(a_no_ack_fields_clear, clk, rst,
    out_valid && !cumulative_valid && !selective_valid,
    ack_connection == '0 && !new_message)
  `ARQ_ASSERT_NEXT(a_advance_fills_output, clk, rst, advance, out_valid)

endmodule
